FILE: design/motorized_detent_lever_controller_defines.svh
// assertion helpers for the detent lever controller
`ifndef MOTORIZED_DETENT_LEVER_CONTROLLER_DEFINES_SVH
`define MOTORIZED_DETENT_LEVER_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MDLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MDLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mdlc_pkg.sv
package mdlc_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 11;
    localparam int TOL_W               = 8;
    localparam int LEVEL_W             = 8;
    localparam int ID_W                = 16;
    localparam int CFG_INDEX_W         = 3;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REVERSE_POS = 3'd0,
        CFG_NEUTRAL_POS = 3'd1,
        CFG_FORWARD_POS = 3'd2,
        CFG_TOLERANCE   = 3'd3,
        CFG_DRIVE_LEVEL = 3'd4
    } cfg_index_t;

    localparam int unsigned REVERSE_POS_RESET = 400;
    localparam int unsigned NEUTRAL_POS_RESET = 830;
    localparam int unsigned FORWARD_POS_RESET = 1260;
    localparam logic [TOL_W-1:0]   TOLERANCE_RESET   = 8'd33;
    localparam logic [LEVEL_W-1:0] DRIVE_LEVEL_RESET = 8'd255;

    // reverser codes
    localparam logic signed [1:0] SETTING_REVERSE = -2'sd1;
    localparam logic signed [1:0] SETTING_NEUTRAL = 2'sd0;
    localparam logic signed [1:0] SETTING_FORWARD = 2'sd1;

endpackage

FILE: design/motorized_detent_lever_controller.sv
// Motorized detent lever controller.
// Input channel (in_valid/in_ready) takes one request per tick while in_ready is high: lever_sample,
// loco_id and loco_setting. Output channel (out_valid/out_ready) returns one
// result per request: motor direction and speed, detent report and mode.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the detent
// positions, arrival tolerance and drive level; cfg_ready is always high and
// writes are expected only while no request is in flight.
// Timing: a request accepted into the input register is evaluated from there and
// lands in the output register once that register is free or being taken; out_valid
// then rises. Throughput: one request per cycle while out_ready stays high, as the
// evaluation between the two registers is combinational.
// A new request is taken while a finished result still waits, as long as the
// input register is empty; when out_ready stays low both registers fill and
// in_ready drops until the output is taken.
// Reset: mode goes to idle, the stored locomotive to 0, registers to their
// default detent positions, tolerance 33 and drive level 255; both stages empty.
`include "motorized_detent_lever_controller_defines.svh"

module motorized_detent_lever_controller
    import mdlc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [SAMPLE_BITS-1:0]        cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [SAMPLE_BITS-1:0]        lever_sample,
    input  logic [ID_W-1:0]               loco_id,
    input  logic signed [1:0]             loco_setting,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          drive_clockwise,
    output logic [LEVEL_W-1:0]            drive_speed,
    output logic                          report_valid,
    output logic signed [1:0]             report_setting,
    output logic [1:0]                    mode_now
);

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_RESETTING = 2'd1,
        MODE_ACCEPTING = 2'd2
    } mode_t;

    localparam int SUM_W = SAMPLE_BITS + 1;

    // configuration registers
    logic [SAMPLE_BITS-1:0] reverse_pos_reg;
    logic [SAMPLE_BITS-1:0] neutral_pos_reg;
    logic [SAMPLE_BITS-1:0] forward_pos_reg;
    logic [TOL_W-1:0]       tolerance_reg;
    logic [LEVEL_W-1:0]     drive_level_reg;

    // input stage
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [ID_W-1:0]        id_reg;
    logic signed [1:0]      setting_reg;

    // controller state
    mode_t                  mode_reg;
    logic [ID_W-1:0]        loco_reg;

    // output stage
    logic                   out_valid_reg;
    logic                   cw_reg;
    logic [LEVEL_W-1:0]     speed_reg;
    logic                   report_valid_reg;
    logic signed [1:0]      report_setting_reg;
    logic [1:0]             mode_now_reg;

    logic                   advance;
    logic                   process;

    mode_t                  mode_cur;
    mode_t                  mode_next;
    logic [SUM_W-1:0]       twice_pos;
    logic [SUM_W-1:0]       low_mid_sum;
    logic [SUM_W-1:0]       high_mid_sum;
    logic signed [1:0]      closest;
    logic signed [1:0]      aim;
    logic [SAMPLE_BITS-1:0] target;
    logic signed [SUM_W-1:0] diff;
    logic [SAMPLE_BITS-1:0] distance;
    logic                   near;
    logic                   cw_next;
    logic [LEVEL_W-1:0]     speed_next;
    logic                   report_valid_next;
    logic signed [1:0]      report_setting_next;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign process   = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_pos_reg <= SAMPLE_BITS'(REVERSE_POS_RESET);
            neutral_pos_reg <= SAMPLE_BITS'(NEUTRAL_POS_RESET);
            forward_pos_reg <= SAMPLE_BITS'(FORWARD_POS_RESET);
            tolerance_reg   <= TOLERANCE_RESET;
            drive_level_reg <= DRIVE_LEVEL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_REVERSE_POS: reverse_pos_reg <= cfg_data;
                CFG_NEUTRAL_POS: neutral_pos_reg <= cfg_data;
                CFG_FORWARD_POS: forward_pos_reg <= cfg_data;
                CFG_TOLERANCE:   tolerance_reg   <= cfg_data[TOL_W-1:0];
                CFG_DRIVE_LEVEL: drive_level_reg <= cfg_data[LEVEL_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg  <= lever_sample;
            id_reg      <= loco_id;
            setting_reg <= loco_setting;
        end
    end

    // a new identifier restarts the homing toward the requested detent
    assign mode_cur = (id_reg != loco_reg) ? MODE_RESETTING : mode_reg;

    assign twice_pos    = {sample_reg, 1'b0};
    assign low_mid_sum  = {1'b0, neutral_pos_reg} + {1'b0, reverse_pos_reg};
    assign high_mid_sum = {1'b0, forward_pos_reg} + {1'b0, neutral_pos_reg};

    // a sample exactly on a midpoint snaps to neutral
    always_comb
    begin
        priority if (twice_pos < low_mid_sum)
            closest = SETTING_REVERSE;
        else if (twice_pos > high_mid_sum)
            closest = SETTING_FORWARD;
        else
            closest = SETTING_NEUTRAL;
    end

    assign aim = (mode_cur == MODE_RESETTING) ? setting_reg : closest;

    // the meaningless code -2 aims at neutral
    always_comb
    begin
        priority if (aim == SETTING_REVERSE)
            target = reverse_pos_reg;
        else if (aim == SETTING_FORWARD)
            target = forward_pos_reg;
        else
            target = neutral_pos_reg;
    end

    assign diff = $signed({1'b0, sample_reg}) - $signed({1'b0, target});
    always_comb
    begin
        if (diff[SUM_W-1])
            distance = SAMPLE_BITS'(-diff);
        else
            distance = diff[SAMPLE_BITS-1:0];
    end
    assign near = distance < SAMPLE_BITS'(tolerance_reg);

    always_comb
    begin
        mode_next           = mode_cur;
        cw_next             = 1'b0;
        speed_next          = '0;
        report_valid_next   = 1'b0;
        report_setting_next = SETTING_NEUTRAL;
        if (mode_cur == MODE_RESETTING || mode_cur == MODE_ACCEPTING)
        begin
            if (near)
            begin
                cw_next = 1'b1;
                if (mode_cur == MODE_RESETTING)
                begin
                    mode_next = MODE_ACCEPTING;
                end
                else
                begin
                    report_valid_next   = 1'b1;
                    report_setting_next = closest;
                end
            end
            else
            begin
                cw_next    = !(sample_reg > target);
                speed_next = drive_level_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_IDLE;
            loco_reg           <= '0;
            out_valid_reg      <= 1'b0;
            cw_reg             <= 1'b0;
            speed_reg          <= '0;
            report_valid_reg   <= 1'b0;
            report_setting_reg <= SETTING_NEUTRAL;
            mode_now_reg       <= MODE_IDLE;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (process)
            begin
                mode_reg           <= mode_next;
                loco_reg           <= id_reg;
                cw_reg             <= cw_next;
                speed_reg          <= speed_next;
                report_valid_reg   <= report_valid_next;
                report_setting_reg <= report_setting_next;
                mode_now_reg       <= mode_next;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign drive_clockwise = cw_reg;
    assign drive_speed     = speed_reg;
    assign report_valid    = report_valid_reg;
    assign report_setting  = report_setting_reg;
    assign mode_now        = mode_now_reg;

    `MDLC_ASSERT_NOW(a_report_only_at_rest, clk, rst_n,
        out_valid && report_valid,
        (mode_now == MODE_ACCEPTING) && (drive_speed == '0) && drive_clockwise,
        "report given while not resting in accepting mode")

    `MDLC_ASSERT_NOW(a_idle_motor_off, clk, rst_n,
        out_valid && (mode_now == MODE_IDLE),
        (drive_speed == '0) && !drive_clockwise && !report_valid,
        "motor commanded while idle")

    `MDLC_ASSERT_NEXT(a_new_loco_leaves_idle, clk, rst_n,
        process && (id_reg != loco_reg),
        (mode_reg == MODE_RESETTING) || (mode_reg == MODE_ACCEPTING),
        "identifier change did not start homing")

    `MDLC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n,
        !in_ready,
        in_valid_reg && out_valid_reg && !out_ready,
        "input stalled with room in the pipeline")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mdlc_pkg::*;

    localparam int SB = SAMPLE_BITS_DEFAULT;
    localparam int NUM_DIRECTED = 23;
    localparam int NUM_PHASES = 7;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_RESETTING = 2'd1,
        MODE_ACCEPTING = 2'd2
    } mode_t;

    typedef struct packed {
        logic                cw;
        logic [LEVEL_W-1:0]  speed;
        logic                rep_valid;
        logic signed [1:0]   rep;
        logic [1:0]          mode;
    } lever_cmd_t;

    typedef struct packed {
        logic [SB-1:0]       lever;
        logic [ID_W-1:0]     id;
        logic signed [1:0]   setting;
        logic                typed;
        lever_cmd_t          want;
    } dir_row_t;

    localparam logic signed [1:0] SETTING_UNUSED = -2'sd2;

    // hand-written results hold for the reset register values
    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        '{11'd0,    16'd0,      SETTING_NEUTRAL, 1'b1,
            '{1'b0, 8'd0,   1'b0, SETTING_NEUTRAL, MODE_IDLE}},
        '{11'd2047, 16'd0,      SETTING_FORWARD, 1'b1,
            '{1'b0, 8'd0,   1'b0, SETTING_NEUTRAL, MODE_IDLE}},
        '{11'd0,    16'd5,      SETTING_FORWARD, 1'b1,
            '{1'b1, 8'd255, 1'b0, SETTING_NEUTRAL, MODE_RESETTING}},
        '{11'd2047, 16'd5,      SETTING_FORWARD, 1'b1,
            '{1'b0, 8'd255, 1'b0, SETTING_NEUTRAL, MODE_RESETTING}},
        '{11'd1260, 16'd5,      SETTING_FORWARD, 1'b1,
            '{1'b1, 8'd0,   1'b0, SETTING_NEUTRAL, MODE_ACCEPTING}},
        '{11'd1260, 16'd5,      SETTING_FORWARD, 1'b1,
            '{1'b1, 8'd0,   1'b1, SETTING_FORWARD, MODE_ACCEPTING}},
        '{11'd400,  16'd5,      SETTING_FORWARD, 1'b1,
            '{1'b1, 8'd0,   1'b1, SETTING_REVERSE, MODE_ACCEPTING}},
        '{11'd615,  16'd5,      SETTING_FORWARD, 1'b1,
            '{1'b1, 8'd255, 1'b0, SETTING_NEUTRAL, MODE_ACCEPTING}},
        '{11'd1045, 16'd5,      SETTING_FORWARD, 1'b1,
            '{1'b0, 8'd255, 1'b0, SETTING_NEUTRAL, MODE_ACCEPTING}},
        '{11'd830,  16'd5,      SETTING_FORWARD, 1'b1,
            '{1'b1, 8'd0,   1'b1, SETTING_NEUTRAL, MODE_ACCEPTING}},
        '{11'd0,    16'd5,      SETTING_FORWARD, 1'b0, '0},
        '{11'd2047, 16'd5,      SETTING_FORWARD, 1'b0, '0},
        '{11'd1292, 16'd5,      SETTING_FORWARD, 1'b0, '0},
        '{11'd1293, 16'd5,      SETTING_FORWARD, 1'b0, '0},
        '{11'd368,  16'd5,      SETTING_FORWARD, 1'b0, '0},
        '{11'd367,  16'd5,      SETTING_FORWARD, 1'b0, '0},
        '{11'd400,  16'd0,      SETTING_REVERSE, 1'b1,
            '{1'b1, 8'd0,   1'b0, SETTING_NEUTRAL, MODE_ACCEPTING}},
        '{11'd830,  16'hFFFF,   SETTING_UNUSED,  1'b1,
            '{1'b1, 8'd0,   1'b0, SETTING_NEUTRAL, MODE_ACCEPTING}},
        '{11'd1000, 16'hFFFF,   SETTING_UNUSED,  1'b0, '0},
        '{11'd2047, 16'hAAAA,   SETTING_REVERSE, 1'b1,
            '{1'b0, 8'd255, 1'b0, SETTING_NEUTRAL, MODE_RESETTING}},
        '{11'h555,  16'h5555,   SETTING_UNUSED,  1'b0, '0},
        '{11'h2AA,  16'h5555,   SETTING_FORWARD, 1'b0, '0},
        '{11'd1260, 16'h5555,   SETTING_FORWARD, 1'b0, '0}
    };

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    cfg_index_t              cfg_index;
    logic [SB-1:0]           cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [SB-1:0]           lever_sample;
    logic [ID_W-1:0]         loco_id;
    logic signed [1:0]       loco_setting;
    logic                    out_valid;
    logic                    out_ready;
    logic                    drive_clockwise;
    logic [LEVEL_W-1:0]      drive_speed;
    logic                    report_valid;
    logic signed [1:0]       report_setting;
    logic [1:0]              mode_now;

    // predictor state and register copy
    mode_t                   ctrl_mode;
    logic [ID_W-1:0]         cur_loco;
    int                      rev_pos;
    int                      neu_pos;
    int                      fwd_pos;
    int                      tol;
    int                      drive_lvl;

    lever_cmd_t              expected_cmds [$];
    int                      mismatch_count;
    int                      cycle_count;
    bit                      calm;
    bit                      hold_out;

    motorized_detent_lever_controller dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .lever_sample    (lever_sample),
        .loco_id         (loco_id),
        .loco_setting    (loco_setting),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .drive_clockwise (drive_clockwise),
        .drive_speed     (drive_speed),
        .report_valid    (report_valid),
        .report_setting  (report_setting),
        .mode_now        (mode_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int detent_of(int setting);
        if (setting == -1)
            return rev_pos;
        if (setting == 1)
            return fwd_pos;
        return neu_pos;
    endfunction

    function automatic bit at_detent(int pos, int target);
        int d;
        d = pos - target;
        if (d < 0)
            d = -d;
        return d < tol;
    endfunction

    // advances the controller state by one tick and returns its motor command
    function automatic lever_cmd_t predict_lever_cmd(logic [SB-1:0] sample,
                                                     logic [ID_W-1:0] id,
                                                     logic signed [1:0] setting);
        lever_cmd_t r;
        int pos;
        int target;
        int closest;
        r = '0;
        pos = sample;
        if (id != cur_loco)
        begin
            ctrl_mode = MODE_RESETTING;
            cur_loco = id;
        end
        if (ctrl_mode == MODE_RESETTING)
        begin
            target = detent_of(setting);
            if (at_detent(pos, target))
            begin
                r.cw = 1'b1;
                ctrl_mode = MODE_ACCEPTING;
            end
            else
            begin
                r.cw = (pos <= target);
                r.speed = drive_lvl[LEVEL_W-1:0];
            end
        end
        else if (ctrl_mode == MODE_ACCEPTING)
        begin
            closest = 0;
            // a sample exactly on a midpoint stays neutral
            if (2 * pos < rev_pos + neu_pos)
                closest = -1;
            else if (2 * pos > fwd_pos + neu_pos)
                closest = 1;
            target = detent_of(closest);
            if (at_detent(pos, target))
            begin
                r.cw = 1'b1;
                r.rep_valid = 1'b1;
                r.rep = closest[1:0];
            end
            else
            begin
                r.cw = (pos <= target);
                r.speed = drive_lvl[LEVEL_W-1:0];
            end
        end
        r.mode = ctrl_mode;
        return r;
    endfunction

    task automatic report_mismatch(string what, lever_cmd_t want, lever_cmd_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $write("%0t: %s: expected cw=%0b speed=%0d rv=%0b rep=%0d mode=%0d",
                   $realtime, what, want.cw, want.speed, want.rep_valid, want.rep,
                   want.mode);
            $display(", got cw=%0b speed=%0d rv=%0b rep=%0d mode=%0d",
                     got.cw, got.speed, got.rep_valid, got.rep, got.mode);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        lever_cmd_t got;
        lever_cmd_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{drive_clockwise, drive_speed, report_valid, report_setting, mode_now};
            if (expected_cmds.size() == 0)
                report_mismatch("result with no request pending", '0, got);
            else
            begin
                want = expected_cmds.pop_front();
                if (got.cw !== want.cw || got.speed !== want.speed
                    || got.rep_valid !== want.rep_valid || got.rep !== want.rep
                    || got.mode !== want.mode)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // receiver side: short random stalls plus one long hold-off on request
    initial
    begin
        int n;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_out)
            begin
                out_ready <= 1'b0;
                for (n = 0; n < LONG_HOLD_CYCLES; n++)
                    @(posedge clk);
                hold_out = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 8);
                repeat (n) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // leaves in_valid high on return when no gap follows
    task automatic send_req(logic [SB-1:0] sample, logic [ID_W-1:0] id,
                            logic signed [1:0] setting, logic typed, lever_cmd_t want);
        lever_cmd_t pred;
        int gap;
        lever_sample <= sample;
        loco_id <= id;
        loco_setting <= setting;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = predict_lever_cmd(sample, id, setting);
        expected_cmds.push_back(typed ? want : pred);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(int rev, int neu, int fwd, int tl, int lvl);
        cfg_index_t idx;
        int value;
        idx = CFG_REVERSE_POS;
        repeat (5)
        begin
            case (idx)
                CFG_REVERSE_POS: value = rev;
                CFG_NEUTRAL_POS: value = neu;
                CFG_FORWARD_POS: value = fwd;
                CFG_TOLERANCE:   value = tl;
                default:         value = lvl;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value[SB-1:0];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx)
                CFG_REVERSE_POS: rev_pos = value;
                CFG_NEUTRAL_POS: neu_pos = value;
                CFG_FORWARD_POS: fwd_pos = value;
                CFG_TOLERANCE:   tol = value;
                default:         drive_lvl = value;
            endcase
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int a;
        int b;
        int v;
        int spread;
        logic [ID_W-1:0] id;
        logic signed [1:0] setting;
        mismatch_count = 0;
        calm = 1'b0;
        hold_out = 1'b0;
        ctrl_mode = MODE_IDLE;
        cur_loco = '0;
        rev_pos = REVERSE_POS_RESET;
        neu_pos = NEUTRAL_POS_RESET;
        fwd_pos = FORWARD_POS_RESET;
        tol = TOLERANCE_RESET;
        drive_lvl = DRIVE_LEVEL_RESET;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_REVERSE_POS;
        cfg_data <= '0;
        in_valid <= 1'b0;
        lever_sample <= '0;
        loco_id <= '0;
        loco_setting <= SETTING_NEUTRAL;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_req(DIRECTED[i].lever, DIRECTED[i].id, DIRECTED[i].setting,
                     DIRECTED[i].typed, DIRECTED[i].want);
        drain();

        id = 16'd7;
        setting = SETTING_FORWARD;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: set_config(0, 1023, 2047, 255, 0);
                1: set_config(2047, 1024, 0, 1, 255);
                // zero tolerance: the lever never counts as arrived
                2: set_config($urandom_range(0, 2047), $urandom_range(0, 2047),
                              $urandom_range(0, 2047), 0, $urandom_range(1, 254));
                NUM_PHASES - 1:
                begin
                    calm = 1'b1;
                    set_config(REVERSE_POS_RESET, NEUTRAL_POS_RESET, FORWARD_POS_RESET,
                               TOLERANCE_RESET, DRIVE_LEVEL_RESET);
                end
                default:
                begin
                    a = $urandom_range(0, 600);
                    b = a + $urandom_range(100, 700);
                    set_config(a, b, b + $urandom_range(100, 740),
                               $urandom_range(8, 80), $urandom_range(1, 255));
                end
            endcase

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (ph == 3 && k == 20)
                    hold_out = 1'b1;
                if (ph == 4 && k == 40)
                    drain();
                if ($urandom_range(0, 99) < 12)
                begin
                    case ($urandom_range(0, 3))
                        0:       id = '0;
                        1:       id = '1;
                        default: id = ID_W'($urandom);
                    endcase
                end
                if ($urandom_range(0, 99) < 15)
                    setting = 2'($urandom_range(0, 3));
                // mostly samples around detents so the mode machine gets exercised
                spread = tol + 3;
                case ($urandom_range(0, 9))
                    0, 1, 2: v = detent_of(setting);
                    3:       v = rev_pos;
                    4:       v = fwd_pos;
                    5:       v = neu_pos;
                    6:       v = (($urandom_range(0, 1) ? rev_pos : fwd_pos) + neu_pos) / 2;
                    default: v = $urandom_range(0, 2047);
                endcase
                if (v != 0 || $urandom_range(0, 1))
                    v = v + int'($urandom_range(0, 2 * spread)) - spread;
                if (v < 0)
                    v = 0;
                if (v > 2047)
                    v = 2047;
                send_req(v[SB-1:0], id, setting, 1'b0, '0);
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/mdlc_pkg.sv
design/motorized_detent_lever_controller.sv
tb/tb_top.sv
